>>> sv/assert_macros.svh
// Assertion macros shared by the mapper modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk_i, disabled while rst_ni is low.
`define LZBM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen on clk_i out of reset.
`define LZBM_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> sv/lzbm_pkg.sv
// Shared types, constants and codes of the lazy zero block mapper.
package lzbm_pkg;

  localparam int BlkW     = 48;
  localparam int RunW     = 17;
  localparam int TagW     = 8;
  localparam int BmW      = 32;
  localparam int CmdW     = 3;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 48;
  localparam int DivSteps = BlkW;
  localparam int DivCntW  = $clog2(DivSteps + 1);

  localparam int MAX_CHUNKS_DEF = 4096;

  localparam logic [RunW-1:0] CHUNK_SIZE_RST = 17'd1024;
  localparam logic [BmW-1:0]  BITMAP_RST     = 32'd1;
  localparam logic [BlkW-1:0] BASE_RST       = 48'd3;

  localparam logic [CfgIdxW-1:0] REG_CHUNK_SIZE = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_BITMAP     = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_BASE_COUNT = 2'd2;

  localparam logic [CmdW-1:0] CMD_READ  = 3'd0;
  localparam logic [CmdW-1:0] CMD_FILL  = 3'd1;
  localparam logic [CmdW-1:0] CMD_ZERO  = 3'd2;
  localparam logic [CmdW-1:0] CMD_WRITE = 3'd3;
  localparam logic [CmdW-1:0] CMD_ERROR = 3'd4;

  typedef struct packed {
    logic            mode;
    logic [BlkW-1:0] block_index;
    logic [TagW-1:0] buffer_tag;
  } lzbm_in_t;

  typedef struct packed {
    logic [CmdW-1:0] command;
    logic [BlkW-1:0] phys_block;
    logic [RunW-1:0] run_length;
    logic [TagW-1:0] out_buffer_tag;
    logic            last;
  } lzbm_out_t;

  typedef enum logic [2:0] {
    RES_ERROR,
    RES_FILL,
    RES_READ,
    RES_WRITE,
    RES_ZERO
  } lzbm_res_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP,
    ST_RANGE,
    ST_DIV,
    ST_CHECK,
    ST_WAIT,
    ST_DECIDE,
    ST_EMIT_ZERO,
    ST_EMIT_LAST
  } lzbm_state_e;

  typedef struct packed {
    logic      clr_step;
    logic      load;
    logic      prep;
    logic      div_step;
    logic      check;
    logic      capture;
    logic      emit;
    logic      set_bit;
    lzbm_res_e kind;
  } lzbm_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic range_err;
    logic div_done;
    logic chunk_err;
    logic mode;
    logic ready;
    logic out_free;
  } lzbm_sts_t;

endpackage

>>> sv/lzbm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lzbm_ram #(
  parameter int Width = 1,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/lzbm_ctrl.sv
// Controller state machine of the mapper: sequences clear, divide, lookup and emit.
`include "assert_macros.svh"

module lzbm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lzbm_pkg::lzbm_sts_t sts_i,
  output lzbm_pkg::lzbm_cmd_t cmd_o
);

  lzbm_pkg::lzbm_state_e state_q, state_d;
  lzbm_pkg::lzbm_res_e   kind_q, kind_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lzbm_pkg::ST_CLEAR;
      kind_q  <= lzbm_pkg::RES_ERROR;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    case (state_q)
      lzbm_pkg::ST_CLEAR: begin
        if (sts_i.clr_done) state_d = lzbm_pkg::ST_IDLE;
      end
      lzbm_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = lzbm_pkg::ST_PREP;
      end
      lzbm_pkg::ST_PREP: begin
        state_d = lzbm_pkg::ST_RANGE;
      end
      lzbm_pkg::ST_RANGE: begin
        if (sts_i.range_err) begin
          state_d = lzbm_pkg::ST_EMIT_LAST;
          kind_d  = lzbm_pkg::RES_ERROR;
        end else begin
          state_d = lzbm_pkg::ST_DIV;
        end
      end
      lzbm_pkg::ST_DIV: begin
        if (sts_i.div_done) state_d = lzbm_pkg::ST_CHECK;
      end
      lzbm_pkg::ST_CHECK: begin
        if (sts_i.chunk_err) begin
          state_d = lzbm_pkg::ST_EMIT_LAST;
          kind_d  = lzbm_pkg::RES_ERROR;
        end else begin
          state_d = lzbm_pkg::ST_WAIT;
        end
      end
      lzbm_pkg::ST_WAIT: begin
        state_d = lzbm_pkg::ST_DECIDE;
      end
      lzbm_pkg::ST_DECIDE: begin
        if (!sts_i.mode) begin
          state_d = lzbm_pkg::ST_EMIT_LAST;
          kind_d  = sts_i.ready ? lzbm_pkg::RES_READ : lzbm_pkg::RES_FILL;
        end else if (sts_i.ready) begin
          state_d = lzbm_pkg::ST_EMIT_LAST;
          kind_d  = lzbm_pkg::RES_WRITE;
        end else begin
          state_d = lzbm_pkg::ST_EMIT_ZERO;
          kind_d  = lzbm_pkg::RES_ZERO;
        end
      end
      lzbm_pkg::ST_EMIT_ZERO: begin
        if (sts_i.out_free) begin
          state_d = lzbm_pkg::ST_EMIT_LAST;
          kind_d  = lzbm_pkg::RES_WRITE;
        end
      end
      lzbm_pkg::ST_EMIT_LAST: begin
        if (sts_i.out_free) state_d = lzbm_pkg::ST_IDLE;
      end
      default: begin
        state_d = lzbm_pkg::ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.kind     = kind_q;
    in_stall_o     = 1'b1;
    case (state_q)
      lzbm_pkg::ST_CLEAR:  cmd_o.clr_step = 1'b1;
      lzbm_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      lzbm_pkg::ST_PREP:   cmd_o.prep     = 1'b1;
      lzbm_pkg::ST_DIV:    cmd_o.div_step = 1'b1;
      lzbm_pkg::ST_CHECK:  cmd_o.check    = 1'b1;
      lzbm_pkg::ST_WAIT:   cmd_o.capture  = 1'b1;
      lzbm_pkg::ST_EMIT_ZERO: begin
        cmd_o.emit    = 1'b1;
        cmd_o.set_bit = sts_i.out_free;
      end
      lzbm_pkg::ST_EMIT_LAST: cmd_o.emit  = 1'b1;
      default: begin
        cmd_o.emit = 1'b0;
      end
    endcase
  end

  // The base write always follows the zero-range result of the same request.
  `LZBM_ASSERT(a_zero_then_write, ($past(state_q) == lzbm_pkg::ST_EMIT_ZERO && state_q != lzbm_pkg::ST_EMIT_ZERO) |-> (state_q == lzbm_pkg::ST_EMIT_LAST && kind_q == lzbm_pkg::RES_WRITE), "zero range not followed by base write")

endmodule

>>> sv/lzbm_dp.sv
// Datapath of the mapper: config registers, chunk divider, address math, result register.
`include "assert_macros.svh"

module lzbm_dp #(
  parameter int MaxChunks = lzbm_pkg::MAX_CHUNKS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lzbm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [lzbm_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  lzbm_pkg::lzbm_in_t             in_data_i,
  input  logic                           out_stall_i,
  output logic                           out_valid_o,
  output lzbm_pkg::lzbm_out_t            out_data_o,
  input  lzbm_pkg::lzbm_cmd_t            cmd_i,
  output lzbm_pkg::lzbm_sts_t            sts_o
);

  localparam int BlkW   = lzbm_pkg::BlkW;
  localparam int RunW   = lzbm_pkg::RunW;
  localparam int TagW   = lzbm_pkg::TagW;
  localparam int BmW    = lzbm_pkg::BmW;
  localparam int ChunkW = $clog2(MaxChunks);

  // Configuration registers
  logic [RunW-1:0] chunk_size_q;
  logic [BmW-1:0]  bitmap_q;
  logic [BlkW-1:0] base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_size_q <= lzbm_pkg::CHUNK_SIZE_RST;
      bitmap_q     <= lzbm_pkg::BITMAP_RST;
      base_q       <= lzbm_pkg::BASE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lzbm_pkg::REG_CHUNK_SIZE: chunk_size_q <= cfg_wdata_i[RunW-1:0];
        lzbm_pkg::REG_BITMAP:     bitmap_q     <= cfg_wdata_i[BmW-1:0];
        lzbm_pkg::REG_BASE_COUNT: base_q       <= cfg_wdata_i[BlkW-1:0];
        default: begin
          chunk_size_q <= chunk_size_q;
        end
      endcase
    end
  end

  logic [RunW-1:0] csize;
  logic [BmW:0]    offset;
  assign csize  = (chunk_size_q == '0) ? RunW'(1) : chunk_size_q;
  assign offset = {1'b0, bitmap_q} + (BmW+1)'(1);

  // Request and working registers
  logic                   mode_q;
  logic [BlkW-1:0]        blk_q;
  logic [TagW-1:0]        tag_q;
  logic [BlkW:0]          phys_q;
  logic [BlkW-1:0]        dvd_q;
  logic [RunW-1:0]        rem_q;
  logic [lzbm_pkg::DivCntW-1:0] cnt_q;
  logic [BlkW-1:0]        start_q;
  logic [BlkW-1:0]        room_q;
  logic                   ready_q;
  logic                   ram_rdata;

  logic [RunW:0] shifted;
  logic          qbit;
  assign shifted = {rem_q, dvd_q[BlkW-1]};
  assign qbit    = (shifted >= {1'b0, csize});

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= in_data_i.mode;
      blk_q  <= in_data_i.block_index;
      tag_q  <= in_data_i.buffer_tag;
      dvd_q  <= in_data_i.block_index;
      rem_q  <= '0;
    end
    if (cmd_i.prep) begin
      phys_q <= {1'b0, blk_q} + (BlkW+1)'(offset);
    end
    if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[BlkW-2:0], qbit};
      rem_q <= qbit ? RunW'(shifted - {1'b0, csize}) : shifted[RunW-1:0];
    end
    // Chunk start on the base device: block minus its offset inside the chunk.
    if (cmd_i.check) begin
      start_q <= phys_q[BlkW-1:0] - BlkW'(rem_q);
    end
    if (cmd_i.capture) begin
      room_q  <= base_q - start_q;
      ready_q <= ram_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.load) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + lzbm_pkg::DivCntW'(1);
    end
  end

  // Clearing pass over the chunk map
  logic [ChunkW-1:0] clr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_q <= clr_q + ChunkW'(1);
    end
  end

  logic [ChunkW-1:0] chunk;
  assign chunk = dvd_q[ChunkW-1:0];

  lzbm_ram #(
    .Width (1),
    .Depth (MaxChunks)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (cmd_i.clr_step | cmd_i.set_bit),
    .waddr_i (cmd_i.clr_step ? clr_q : chunk),
    .wdata_i (~cmd_i.clr_step),
    .re_i    (cmd_i.check),
    .raddr_i (chunk),
    .rdata_o (ram_rdata)
  );

  // Result register
  logic                out_valid_q;
  lzbm_pkg::lzbm_out_t out_q, out_d;
  logic                out_free, out_load;
  logic [RunW-1:0]     run;

  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = cmd_i.emit && out_free;
  assign run      = (room_q < BlkW'(csize)) ? room_q[RunW-1:0] : csize;

  always_comb begin
    out_d.out_buffer_tag = tag_q;
    out_d.phys_block     = phys_q[BlkW-1:0];
    out_d.run_length     = RunW'(1);
    out_d.last           = 1'b1;
    case (cmd_i.kind)
      lzbm_pkg::RES_ERROR: begin
        out_d.command    = lzbm_pkg::CMD_ERROR;
        out_d.phys_block = '0;
        out_d.run_length = '0;
      end
      lzbm_pkg::RES_FILL: begin
        out_d.command    = lzbm_pkg::CMD_FILL;
        out_d.phys_block = '0;
      end
      lzbm_pkg::RES_READ:  out_d.command = lzbm_pkg::CMD_READ;
      lzbm_pkg::RES_WRITE: out_d.command = lzbm_pkg::CMD_WRITE;
      lzbm_pkg::RES_ZERO: begin
        out_d.command    = lzbm_pkg::CMD_ZERO;
        out_d.phys_block = start_q;
        out_d.run_length = run;
        out_d.last       = 1'b0;
      end
      default: begin
        out_d.command = lzbm_pkg::CMD_ERROR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign sts_o.clr_done  = (clr_q == ChunkW'(MaxChunks - 1));
  assign sts_o.range_err = (phys_q >= {1'b0, base_q});
  assign sts_o.div_done  = (cnt_q == lzbm_pkg::DivCntW'(lzbm_pkg::DivSteps - 1));
  assign sts_o.chunk_err = (dvd_q >= BlkW'(MaxChunks));
  assign sts_o.mode      = mode_q;
  assign sts_o.ready     = ready_q;
  assign sts_o.out_free  = out_free;

  // Divider remainder stays below the chunk size after every step.
  `LZBM_ASSERT(a_rem_bound, cmd_i.div_step |=> (rem_q < csize), "divider remainder out of range")
  // A zero range covers at least one block and never more than a chunk.
  `LZBM_ASSERT(a_zero_run, (out_load && out_d.command == lzbm_pkg::CMD_ZERO) |-> (out_d.run_length != '0 && out_d.run_length <= csize), "zero range length out of range")

endmodule

>>> sv/lazy_zero_block_mapper.sv
// Top level of the lazy zero block mapper: controller, datapath and chunk map.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+------------------------------
//  in      | input     | in_valid_i / in_stall_o  | in_data_i  (mode, block, tag)
//  out     | output    | out_valid_o / out_stall_i| out_data_o (command ... last)
//  cfg     | input     | cfg_we_i                 | cfg_idx_i, cfg_wdata_i
//
// After reset the chunk map is swept to zero, one entry a cycle, all MAX_CHUNKS
// entries; requests stall during the sweep while config writes are taken.
// A request is one transfer in; a mapped request then runs through PREP, RANGE,
// 48 divider steps, lookup, RAM read, decide and emit; a first write to a chunk
// emits its zero range first. Requests wait until the last result is registered.
// A block past the logical end is flagged at RANGE and gets its error result.
// The chunk index comes from a restoring divider, one quotient bit per cycle.
// The result register lets the next request in while a result waits under stall.
module lazy_zero_block_mapper #(
  parameter int MAX_CHUNKS = lzbm_pkg::MAX_CHUNKS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lzbm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lzbm_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  lzbm_pkg::lzbm_in_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output lzbm_pkg::lzbm_out_t           out_data_o
);

  // Command and status between the sequencer and the datapath
  lzbm_pkg::lzbm_cmd_t cmd;
  lzbm_pkg::lzbm_sts_t sts;

  // Sequence sweep, divide, map lookup and result emission.
  lzbm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Hold registers and request state, compute chunk and base addresses,
  // own the chunk map and the result register.
  lzbm_dp #(
    .MaxChunks (MAX_CHUNKS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

>>> tb/sv/lzbm_checker.sv
`timescale 1ns / 1ps
// Checker of the lazy zero block mapper: watches the channels, predicts commands and compares.
module lzbm_checker
  import lzbm_pkg::*;
#(
  parameter int MAX_CHUNKS = MAX_CHUNKS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  lzbm_in_t            in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  lzbm_out_t           out_data_i,
  output int                  mismatches_o,
  output int                  outstanding_o,
  output int                  checked_o
);

  logic [RunW-1:0] chunk_size_q;
  logic [BmW-1:0]  bitmap_q;
  logic [BlkW-1:0] base_count_q;
  bit              chunk_ready [MAX_CHUNKS];
  lzbm_out_t       pending_cmds [$];

  function automatic lzbm_out_t make_cmd(input logic [CmdW-1:0] cmd,
                                         input longint unsigned phys,
                                         input longint unsigned run,
                                         input logic [TagW-1:0] tag,
                                         input logic last);
    lzbm_out_t c;
    c.command        = cmd;
    c.phys_block     = phys[BlkW-1:0];
    c.run_length     = run[RunW-1:0];
    c.out_buffer_tag = tag;
    c.last           = last;
    return c;
  endfunction

  // Work out the commands one request causes and queue them in order.
  task automatic map_request(input lzbm_in_t req);
    longint unsigned blk, csize, offset, logical, chunk, phys, start, room, run;
    blk     = 64'(req.block_index);
    csize   = (chunk_size_q == '0) ? 64'd1 : 64'(chunk_size_q);
    offset  = 64'(bitmap_q) + 64'd1;
    logical = (64'(base_count_q) > offset) ? 64'(base_count_q) - offset : 64'd0;
    chunk   = blk / csize;
    phys    = blk + offset;
    if (blk >= logical || chunk >= 64'(MAX_CHUNKS)) begin
      pending_cmds.push_back(make_cmd(CMD_ERROR, 0, 0, req.buffer_tag, 1'b1));
    end else if (!req.mode) begin
      // mode clear means a read
      if (!chunk_ready[chunk]) begin
        pending_cmds.push_back(make_cmd(CMD_FILL, 0, 1, req.buffer_tag, 1'b1));
      end else begin
        pending_cmds.push_back(make_cmd(CMD_READ, phys, 1, req.buffer_tag, 1'b1));
      end
    end else begin
      if (!chunk_ready[chunk]) begin
        // zero the whole chunk first, cut off at the base device end
        start = chunk * csize + offset;
        room  = 64'(base_count_q) - start;
        run   = (room < csize) ? room : csize;
        pending_cmds.push_back(make_cmd(CMD_ZERO, start, run, req.buffer_tag, 1'b0));
        chunk_ready[chunk] = 1'b1;
      end
      pending_cmds.push_back(make_cmd(CMD_WRITE, phys, 1, req.buffer_tag, 1'b1));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    lzbm_out_t want;
    if (!rst_ni) begin
      pending_cmds.delete();
      foreach (chunk_ready[i]) chunk_ready[i] = 1'b0;
      chunk_size_q = CHUNK_SIZE_RST;
      bitmap_q     = BITMAP_RST;
      base_count_q = BASE_RST;
      mismatches_o = 0;
      checked_o    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pending_cmds.size() == 0) begin
          if (mismatches_o < 10)
            $display("%0t: unexpected command %0d phys %0h run %0d tag %0h last %0b", $time,
                     out_data_i.command, out_data_i.phys_block, out_data_i.run_length,
                     out_data_i.out_buffer_tag, out_data_i.last);
          mismatches_o++;
        end else begin
          want = pending_cmds.pop_front();
          checked_o++;
          if (out_data_i.command !== want.command ||
              out_data_i.phys_block !== want.phys_block ||
              out_data_i.run_length !== want.run_length ||
              out_data_i.out_buffer_tag !== want.out_buffer_tag ||
              out_data_i.last !== want.last) begin
            if (mismatches_o < 10)
              $display({"%0t: expected cmd %0d phys %0h run %0d tag %0h last %0b,",
                        " got cmd %0d phys %0h run %0d tag %0h last %0b"},
                       $time, want.command, want.phys_block, want.run_length,
                       want.out_buffer_tag, want.last, out_data_i.command,
                       out_data_i.phys_block, out_data_i.run_length,
                       out_data_i.out_buffer_tag, out_data_i.last);
            mismatches_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) map_request(in_data_i);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CHUNK_SIZE: chunk_size_q = cfg_wdata_i[RunW-1:0];
          REG_BITMAP:     bitmap_q     = cfg_wdata_i[BmW-1:0];
          REG_BASE_COUNT: base_count_q = cfg_wdata_i;
          default: ;
        endcase
      end
    end
    outstanding_o = pending_cmds.size();
  end

endmodule

>>> tb/sv/tb_lazy_zero_block_mapper.sv
`timescale 1ns / 1ps
// Top of the lazy zero block mapper testbench: clock, reset, stimulus and verdict.
module tb_lazy_zero_block_mapper;
  import lzbm_pkg::*;

  localparam int LIMIT_CYCLES      = 400_000;
  localparam int HOLD_CYCLES       = 300;
  localparam int SETTLE_CYCLES     = 8;
  localparam int RANDOM_SETTINGS   = 10;
  localparam int ITEMS_PER_SETTING = 62;

  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  localparam logic [BlkW-1:0] BLK_MAX = '1;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                in_valid_i;
  logic                in_stall_o;
  lzbm_in_t            in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  lzbm_out_t           out_data_o;

  int mismatches, outstanding, checked;
  int cycle_count = 0;
  int sent, settings;
  int gap_pct, stall_pct;
  bit quiet, hold_req, hold_done;

  // Shadow of the current register setting, used to aim the random blocks.
  logic [RunW-1:0]  cur_chunk;
  logic [BmW-1:0]   cur_bitmap;
  logic [BlkW-1:0]  cur_base;
  longint unsigned  win_chunk;

  lazy_zero_block_mapper dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  lzbm_checker mapping_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .in_data_i     (in_data_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_i    (out_data_o),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding),
    .checked_o     (checked)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Guard against a hung handshake; the limit is several times the slowest legal run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Output side: random stall bursts, plus one long hold-off that lets the block back up
  // until it stalls its input.
  initial begin
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic longint unsigned rand_below(input longint unsigned n);
    return {$urandom, $urandom} % n;
  endfunction

  // Offer one request and hold it until the transfer happens. Call just after a rising edge.
  task automatic send_request(input logic mode, input logic [BlkW-1:0] blk,
                              input logic [TagW-1:0] tag);
    lzbm_in_t req;
    req.mode        = mode;
    req.block_index = blk;
    req.buffer_tag  = tag;
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent++;
  endtask

  // Drop valid, wait for every expected command, then let the block go quiet.
  task automatic settle_block();
    in_valid_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic apply_setting(input logic [RunW-1:0] chunk, input logic [BmW-1:0] bm,
                               input logic [BlkW-1:0] base);
    cur_chunk  = chunk;
    cur_bitmap = bm;
    cur_base   = base;
    write_reg(REG_CHUNK_SIZE, CfgDataW'(chunk));
    write_reg(REG_BITMAP, CfgDataW'(bm));
    write_reg(REG_BASE_COUNT, base);
    settings++;
  endtask

  // Pick a setting: mostly small chunks and short devices, with the extremes mixed in.
  task automatic random_setting();
    logic [RunW-1:0] chunk;
    logic [BmW-1:0]  bm;
    longint unsigned csz, offset, chunks, base;
    case ($urandom_range(0, 7))
      0:       chunk = '0;
      1:       chunk = 17'h10000;
      2, 3, 4: chunk = RunW'($urandom_range(1, 32));
      5:       chunk = RunW'($urandom_range(33, 2048));
      default: chunk = RunW'($urandom_range(1, 65536));
    endcase
    csz = (chunk == '0) ? 64'd1 : 64'(chunk);
    case ($urandom_range(0, 9))
      0:       bm = '1;
      1, 2:    bm = $urandom;
      default: bm = $urandom_range(1, 64);
    endcase
    if (bm == '0) bm = 1;
    offset = 64'(bm) + 64'd1;
    chunks = ($urandom_range(0, 5) == 0) ? $urandom_range(4000, 4200) : $urandom_range(1, 600);
    case ($urandom_range(0, 19))
      0:       base = offset - $urandom_range(0, 1);
      1:       base = 64'(BLK_MAX);
      default: base = offset + chunks * csz - rand_below(csz);
    endcase
    win_chunk = rand_below(chunks);
    apply_setting(chunk, bm, base[BlkW-1:0]);
  endtask

  // Aim most requests at a few neighboring chunks so first writes, repeats and fills mix;
  // the rest hit the logical end, just past it, or anywhere.
  function automatic logic [BlkW-1:0] pick_block();
    longint unsigned csz, offset, logical, blk;
    int r;
    csz     = (cur_chunk == '0) ? 64'd1 : 64'(cur_chunk);
    offset  = 64'(cur_bitmap) + 64'd1;
    logical = (64'(cur_base) > offset) ? 64'(cur_base) - offset : 64'd0;
    r       = $urandom_range(0, 99);
    if (logical == 0 || r >= 90) begin
      blk = {$urandom, $urandom};
    end else if (r < 70) begin
      blk = win_chunk * csz + rand_below(csz * 8);
      if (blk >= logical) blk = rand_below(logical);
    end else if (r < 80) begin
      blk = logical - 1 - rand_below((logical < 4) ? logical : 64'd4);
    end else begin
      blk = logical + rand_below(4);
    end
    return blk[BlkW-1:0];
  endfunction

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = REG_CHUNK_SIZE;
    cfg_wdata_i = '0;
    quiet       = 1'b0;
    hold_req    = 1'b0;
    hold_done   = 1'b0;
    gap_pct     = 0;
    stall_pct   = 0;
    sent        = 0;
    settings    = 1;
    win_chunk   = 0;
    cur_chunk   = CHUNK_SIZE_RST;
    cur_bitmap  = BITMAP_RST;
    cur_base    = BASE_RST;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset setting: one logical block. Requests wait out the clearing sweep.
    send_request(REQ_READ, 48'd0, 8'h00);
    send_request(REQ_WRITE, 48'd0, 8'hFF);
    send_request(REQ_READ, 48'd0, 8'hA5);
    send_request(REQ_WRITE, 48'd0, 8'h5A);
    send_request(REQ_READ, 48'd1, 8'h01);
    send_request(REQ_WRITE, BLK_MAX, 8'h80);
    settle_block();

    // Zero chunk size acts as one; widest bitmap and base. Top chunk, then chunk overflow.
    apply_setting('0, '1, BLK_MAX);
    send_request(REQ_READ, 48'd4095, 8'h11);
    send_request(REQ_WRITE, 48'd4095, 8'h22);
    send_request(REQ_READ, 48'd4095, 8'h33);
    send_request(REQ_WRITE, 48'd4096, 8'h44);
    send_request(REQ_READ, 48'h7FFF_FFFF_FFFF, 8'h55);
    send_request(REQ_READ, 48'hFFFE_FFFF_FFFE, 8'h66);
    send_request(REQ_READ, 48'hFFFE_FFFF_FFFF, 8'h77);
    send_request(REQ_READ, 48'd0, 8'h88);
    settle_block();

    // Largest chunk: a full 64K zero range, and the first block past the last chunk.
    apply_setting(17'h10000, 32'd1, BLK_MAX);
    send_request(REQ_WRITE, 48'h0FFF_FFFF, 8'h99);
    send_request(REQ_WRITE, 48'h0064_0000, 8'hAA);
    send_request(REQ_READ, 48'h1000_0000, 8'hBB);
    settle_block();

    // No logical blocks at all: equal to the offset, then below it.
    apply_setting(17'd1024, 32'd5, 48'd6);
    send_request(REQ_READ, 48'd0, 8'hCC);
    send_request(REQ_WRITE, 48'd0, 8'hDD);
    settle_block();
    write_reg(REG_BASE_COUNT, 48'd2);
    cur_base = 48'd2;
    send_request(REQ_READ, 48'd3, 8'hEE);
    settle_block();

    // Last chunk runs past the device end, so its zero range is cut short.
    apply_setting(17'd100, 32'd3, 48'd1054);
    send_request(REQ_WRITE, 48'd1049, 8'h0F);
    send_request(REQ_READ, 48'd1000, 8'hF0);
    send_request(REQ_READ, 48'd999, 8'h3C);
    settle_block();

    // Random settings; the third carries the long output hold, the last runs without idling.
    for (int p = 0; p < RANDOM_SETTINGS; p++) begin
      random_setting();
      quiet = (p == RANDOM_SETTINGS - 1);
      case ($urandom_range(0, 2))
        0:       gap_pct = 0;
        1:       gap_pct = 10;
        default: gap_pct = 35;
      endcase
      case ($urandom_range(0, 2))
        0:       stall_pct = 0;
        1:       stall_pct = 10;
        default: stall_pct = 35;
      endcase
      if (p == 2) hold_req = 1'b1;
      for (int i = 0; i < ITEMS_PER_SETTING; i++)
        send_request(logic'($urandom_range(0, 1)), pick_block(), TagW'($urandom_range(0, 255)));
      settle_block();
    end

    $display("Ran %0d requests under %0d register settings, %0d commands compared,",
             sent, settings, checked);
    $display("with random gaps and stalls and one long output hold that backed up the input.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
